[hdl/kcr_pkg.sv]
// ---------------------------------------------------------------------------
// kcr_pkg: shared types and constants of the keyframe collinear reducer
// Word formats, arithmetic widths, sequencer states and the product schedule.
// ---------------------------------------------------------------------------
package kcr_pkg;

  localparam int COORD_BITS = 24;
  localparam int STAMP_BITS = 32;

  // difference of two coordinates
  localparam int DW = COORD_BITS + 1;
  // widest exact value: len2^2 * tol^2
  localparam int PW = 4 * COORD_BITS + 40;
  // widest second operand: cross term or len2, signed
  localparam int BW = 2 * COORD_BITS + 5;
  // 8-bit digits of the second operand
  localparam int MUL_DIGITS = (BW + 7) / 8;
  localparam int CNT_BITS   = $clog2(MUL_DIGITS + 1);

  localparam int NSTEP     = 18;
  localparam int STEP_BITS = 5;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] key_x;
    logic signed [COORD_BITS-1:0] key_y;
    logic signed [COORD_BITS-1:0] key_z;
    logic        [STAMP_BITS-1:0] key_time;
    logic                         track_end;
  } key_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] kept_x;
    logic signed [COORD_BITS-1:0] kept_y;
    logic signed [COORD_BITS-1:0] kept_z;
    logic        [STAMP_BITS-1:0] kept_time;
    logic                         kept_last;
  } kept_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC_START,
    ST_CALC_WAIT,
    ST_DECIDE,
    ST_EMIT_PEND,
    ST_FINISH,
    ST_EMIT_KEY
  } state_t;

  // operand sources of the shared multiplier
  typedef enum logic [3:0] {
    OP_PD0, OP_PD1, OP_PD2,
    OP_V0, OP_V1, OP_V2,
    OP_C0, OP_C1, OP_C2,
    OP_LEN2, OP_RHS, OP_TOL
  } opnd_t;

  // accumulators written by a product
  typedef enum logic [2:0] {
    ACC_T, ACC_LEN2, ACC_C0, ACC_C1, ACC_C2, ACC_LHS, ACC_RHS
  } acc_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    acc_t  tgt;
    logic  sub;
    logic  replace;
  } step_t;

  localparam int REG_ENABLE = 0;
  localparam int REG_TOL    = 1;

  // product schedule: dot, length, cross terms, squared cross, rhs chain
  function automatic step_t step_rom(input logic [STEP_BITS-1:0] s);
    step_t r;
    r = '{a: OP_PD0, b: OP_V0, tgt: ACC_T, sub: 1'b0, replace: 1'b0};
    case (s)
      5'd0:  r = '{OP_PD0, OP_V0, ACC_T, 1'b0, 1'b0};
      5'd1:  r = '{OP_PD1, OP_V1, ACC_T, 1'b0, 1'b0};
      5'd2:  r = '{OP_PD2, OP_V2, ACC_T, 1'b0, 1'b0};
      5'd3:  r = '{OP_PD0, OP_PD0, ACC_LEN2, 1'b0, 1'b0};
      5'd4:  r = '{OP_PD1, OP_PD1, ACC_LEN2, 1'b0, 1'b0};
      5'd5:  r = '{OP_PD2, OP_PD2, ACC_LEN2, 1'b0, 1'b0};
      5'd6:  r = '{OP_PD1, OP_V2, ACC_C0, 1'b0, 1'b0};
      5'd7:  r = '{OP_PD2, OP_V1, ACC_C0, 1'b1, 1'b0};
      5'd8:  r = '{OP_PD2, OP_V0, ACC_C1, 1'b0, 1'b0};
      5'd9:  r = '{OP_PD0, OP_V2, ACC_C1, 1'b1, 1'b0};
      5'd10: r = '{OP_PD0, OP_V1, ACC_C2, 1'b0, 1'b0};
      5'd11: r = '{OP_PD1, OP_V0, ACC_C2, 1'b1, 1'b0};
      5'd12: r = '{OP_C0, OP_C0, ACC_LHS, 1'b0, 1'b0};
      5'd13: r = '{OP_C1, OP_C1, ACC_LHS, 1'b0, 1'b0};
      5'd14: r = '{OP_C2, OP_C2, ACC_LHS, 1'b0, 1'b0};
      5'd15: r = '{OP_LEN2, OP_LEN2, ACC_RHS, 1'b0, 1'b1};
      5'd16: r = '{OP_RHS, OP_TOL, ACC_RHS, 1'b0, 1'b1};
      5'd17: r = '{OP_RHS, OP_TOL, ACC_RHS, 1'b0, 1'b1};
      default: r = '{OP_PD0, OP_V0, ACC_T, 1'b0, 1'b0};
    endcase
    return r;
  endfunction

endpackage

[hdl/keyframe_collinear_reducer.sv]
// ---------------------------------------------------------------------------
// keyframe_collinear_reducer: drops keys lying close to their neighbors' line
// Keeps an anchor and one pending key and tests the pending key per new key.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_word carries one key per word; the
//   output channel out_valid/out_stall/out_word carries kept keys. A key
//   gives zero, one or two kept words. The APB port sets reduce_enable
//   (offset 0) and error_tolerance (offset 4); write only while idle.
// Operation:
//   A key that needs the collinearity test runs 18 products through one
//   8-bit-digit serial multiplier, then the decide and finish states and
//   up to two emit states; an emit waits while the receiver stalls. Other
//   keys go from accept straight to the emit or finish states.
//   in_stall is high until the key is fully handled.
// Reset:
//   Synchronous rst clears the track state and loads reduce_enable = 1,
//   error_tolerance = 128.
// Stall:
//   A kept word is held in the output register while out_stall is high;
//   the sequencer waits for that register before it writes another word.
// ---------------------------------------------------------------------------
module keyframe_collinear_reducer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  kcr_pkg::key_word_t    in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output kcr_pkg::kept_word_t   out_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import kcr_pkg::*;

  state_t state, state_next;

  logic        reduce_enable;
  logic [15:0] error_tolerance;

  key_word_t                    key_r;
  logic signed [COORD_BITS-1:0] anchor [3];
  logic signed [COORD_BITS-1:0] pend [3];
  logic [STAMP_BITS-1:0]        pend_time;
  logic                         anchor_valid;
  logic                         pending_valid;

  logic signed [DW-1:0] pd [3];
  logic signed [DW-1:0] v  [3];
  logic [PW-1:0] t_acc, len2, c_acc [3], lhs, rhs;
  logic [STEP_BITS-1:0] step;
  step_t cur;

  logic          accept, out_free, emit_pend, emit_key, mul_start, mul_done;
  logic [PW-1:0] opa, opb_w, prod, tgt_cur, tgt_new;
  logic          drop;

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {16'b0, error_tolerance} : {31'b0, reduce_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_enable   <= 1'b1;
      error_tolerance <= 16'd128;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == 1'(REG_TOL)) error_tolerance <= pwdata[15:0];
      else                          reduce_enable   <= pwdata[0];
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cur      = step_rom(step);

  // operand selection
  always_comb begin
    case (cur.a)
      OP_PD0:  opa = PW'(pd[0]);
      OP_PD1:  opa = PW'(pd[1]);
      OP_PD2:  opa = PW'(pd[2]);
      OP_C0:   opa = c_acc[0];
      OP_C1:   opa = c_acc[1];
      OP_C2:   opa = c_acc[2];
      OP_LEN2: opa = len2;
      OP_RHS:  opa = rhs;
      default: opa = '0;
    endcase
  end

  always_comb begin
    case (cur.b)
      OP_PD0:  opb_w = PW'(pd[0]);
      OP_PD1:  opb_w = PW'(pd[1]);
      OP_PD2:  opb_w = PW'(pd[2]);
      OP_V0:   opb_w = PW'(v[0]);
      OP_V1:   opb_w = PW'(v[1]);
      OP_V2:   opb_w = PW'(v[2]);
      OP_C0:   opb_w = c_acc[0];
      OP_C1:   opb_w = c_acc[1];
      OP_C2:   opb_w = c_acc[2];
      OP_LEN2: opb_w = len2;
      OP_TOL:  opb_w = PW'(error_tolerance);
      default: opb_w = '0;
    endcase
  end

  kcr_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (opa),
    .b     (opb_w[BW-1:0]),
    .done  (mul_done),
    .prod  (prod)
  );

  // accumulate into the target
  always_comb begin
    case (cur.tgt)
      ACC_T:    tgt_cur = t_acc;
      ACC_LEN2: tgt_cur = len2;
      ACC_C0:   tgt_cur = c_acc[0];
      ACC_C1:   tgt_cur = c_acc[1];
      ACC_C2:   tgt_cur = c_acc[2];
      ACC_LHS:  tgt_cur = lhs;
      ACC_RHS:  tgt_cur = rhs;
      default:  tgt_cur = '0;
    endcase
    if (cur.replace)  tgt_new = prod;
    else if (cur.sub) tgt_new = tgt_cur - prod;
    else              tgt_new = tgt_cur + prod;
  end

  // drop test on finished sums
  always_comb begin
    if (len2 == '0)
      drop = (v[0] == '0) && (v[1] == '0) && (v[2] == '0);
    else
      drop = !t_acc[PW-1] && ($signed(t_acc) <= $signed(len2))
             && ((lhs << 16) <= rhs);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!anchor_valid)                       state_next = ST_EMIT_KEY;
          else if (pending_valid && reduce_enable) state_next = ST_CALC_START;
          else if (pending_valid)                  state_next = ST_EMIT_PEND;
          else                                     state_next = ST_FINISH;
        end
      end
      ST_CALC_START: state_next = ST_CALC_WAIT;
      ST_CALC_WAIT: begin
        if (mul_done)
          state_next = (step == STEP_BITS'(NSTEP - 1)) ? ST_DECIDE : ST_CALC_START;
      end
      ST_DECIDE:    state_next = drop ? ST_FINISH : ST_EMIT_PEND;
      ST_EMIT_PEND: if (out_free) state_next = ST_FINISH;
      ST_FINISH:    state_next = key_r.track_end ? ST_EMIT_KEY : ST_IDLE;
      ST_EMIT_KEY:  if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mul_start = (state == ST_CALC_START);
    emit_pend = (state == ST_EMIT_PEND) && out_free;
    emit_key  = (state == ST_EMIT_KEY) && out_free;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      anchor_valid  <= 1'b0;
      pending_valid <= 1'b0;
      out_valid     <= 1'b0;
      step          <= '0;
    end else begin
      state <= state_next;
      if (emit_pend || emit_key) out_valid <= 1'b1;
      else if (!out_stall)       out_valid <= 1'b0;
      if (accept) step <= '0;
      else if (state == ST_CALC_WAIT && mul_done) step <= step + 1'b1;
      if (emit_pend) pending_valid <= 1'b0;
      if (state == ST_FINISH && !key_r.track_end) pending_valid <= 1'b1;
      if (emit_key) begin
        anchor_valid  <= !key_r.track_end;
        pending_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        anchor[i] <= '0;
        pend[i]   <= '0;
      end
      pend_time <= '0;
    end else begin
      if (accept) begin
        key_r <= in_word;
        pd[0] <= DW'(in_word.key_x) - DW'(anchor[0]);
        pd[1] <= DW'(in_word.key_y) - DW'(anchor[1]);
        pd[2] <= DW'(in_word.key_z) - DW'(anchor[2]);
        for (int i = 0; i < 3; i++) begin
          v[i]     <= DW'(pend[i]) - DW'(anchor[i]);
          c_acc[i] <= '0;
        end
        t_acc <= '0;
        len2  <= '0;
        lhs   <= '0;
      end else if (state == ST_CALC_WAIT && mul_done) begin
        case (cur.tgt)
          ACC_T:    t_acc    <= tgt_new;
          ACC_LEN2: len2     <= tgt_new;
          ACC_C0:   c_acc[0] <= tgt_new;
          ACC_C1:   c_acc[1] <= tgt_new;
          ACC_C2:   c_acc[2] <= tgt_new;
          ACC_LHS:  lhs      <= tgt_new;
          ACC_RHS:  rhs      <= tgt_new;
          default:  lhs      <= lhs;
        endcase
      end

      if (emit_pend) begin
        out_word <= '{pend[0], pend[1], pend[2], pend_time, 1'b0};
        for (int i = 0; i < 3; i++) anchor[i] <= pend[i];
      end
      if (state == ST_FINISH && !key_r.track_end) begin
        pend[0]   <= key_r.key_x;
        pend[1]   <= key_r.key_y;
        pend[2]   <= key_r.key_z;
        pend_time <= key_r.key_time;
      end
      if (emit_key) begin
        out_word <= '{key_r.key_x, key_r.key_y, key_r.key_z, key_r.key_time,
                      key_r.track_end};
        if (key_r.track_end) begin
          for (int i = 0; i < 3; i++) begin
            anchor[i] <= '0;
            pend[i]   <= '0;
          end
          pend_time <= '0;
        end else begin
          anchor[0] <= key_r.key_x;
          anchor[1] <= key_r.key_y;
          anchor[2] <= key_r.key_z;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_pend_has_anchor: assert property (@(posedge clk) disable iff (rst)
    pending_valid |-> anchor_valid) else $error("pending key without anchor");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_CALC_WAIT) else $error("multiplier done out of turn");
  a_decide_signs: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECIDE |-> !lhs[PW-1] && !rhs[PW-1] && !len2[PW-1])
    else $error("negative square sum");
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (emit_pend || emit_key) |-> !(out_valid && out_stall))
    else $error("output word overwritten");
`endif

endmodule

[hdl/kcr_mul.sv]
// ---------------------------------------------------------------------------
// kcr_mul: digit-serial signed multiplier
// Multiplies a wide signed operand by a narrower one, eight bits a cycle.
// ---------------------------------------------------------------------------
module kcr_mul (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [kcr_pkg::PW-1:0]   a,
  input  logic [kcr_pkg::BW-1:0]   b,
  output logic                     done,
  output logic [kcr_pkg::PW-1:0]   prod
);
  import kcr_pkg::*;

  logic [PW-1:0]       amag;
  logic [BW-1:0]       bmag;
  logic [PW-1:0]       acc;
  logic                neg;
  logic                busy;
  logic [CNT_BITS-1:0] cnt;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(MUL_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: one 8-bit digit of b per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      amag <= a[PW-1] ? (~a + 1'b1) : a;
      bmag <= b[BW-1] ? (~b + 1'b1) : b;
      neg  <= a[PW-1] ^ b[BW-1];
      acc  <= '0;
    end else if (busy) begin
      acc  <= acc + (amag * PW'(bmag[7:0]));
      amag <= amag << 8;
      bmag <= bmag >> 8;
    end
  end

  assign prod = neg ? (~acc + 1'b1) : acc;

endmodule
